### sv/bhfc_pkg.sv
// ----------------------------------------------------------------------------
// bhfc_pkg
// Shared types and constants for the bus header and frame chunker.
// ----------------------------------------------------------------------------
package bhfc_pkg;

   localparam int unsigned GROUP_BITS = 24;      // widest bit group (3-byte header)
   localparam int unsigned NBITS_W    = 5;       // holds 0..24
   localparam int unsigned STORE_W    = 40;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned FS_W       = 4;
   localparam int unsigned CHUNK_W    = 16;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [FS_W-1:0] FRAME_SIZE_RESET = 4'd11;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // one classified item: right-aligned bits to append to the stream
   typedef struct packed {
      logic                  clear;   // header: drop pending bits first
      logic                  last;
      logic [NBITS_W-1:0]    nbits;
      logic [GROUP_BITS-1:0] bits;
   } group_type;

endpackage

### sv/bhfc_front.sv
// ----------------------------------------------------------------------------
// bhfc_front
// Classifies an input beat and packs header or payload into a bit group.
// ----------------------------------------------------------------------------
module bhfc_front
   import bhfc_pkg::*;
(
   input  logic              kind,
   input  logic signed [7:0] dest_addr,
   input  logic signed [7:0] source_addr,
   input  logic [7:0]        command_code,
   input  logic [7:0]        payload_byte,
   input  logic [3:0]        valid_bits,
   input  logic              last_item,
   output group_type         group
);

   logic       dshort;
   logic       sshort;
   logic [3:0] vused;
   logic [7:0] dbits;
   logic [7:0] sbits;

   assign dshort = dest_addr[7];
   assign sshort = source_addr[7];
   assign dbits  = dest_addr;
   assign sbits  = source_addr;
   assign vused  = (valid_bits > 4'd8) ? 4'd8 : valid_bits;

   always_comb begin
      group.last  = last_item;
      group.clear = 1'b0;
      group.nbits = '0;
      group.bits  = '0;
      if (kind == KIND_HEADER) begin
         group.clear = 1'b1;
         if (dshort && sshort) begin
            group.nbits = 5'd8;
            group.bits  = {16'b0, 1'b1, dbits[1:0], 1'b1, sbits[1:0], command_code[1:0]};
         end else if (dshort) begin
            group.nbits = 5'd16;
            group.bits  = {8'b0, 1'b1, dbits[1:0], sbits[7:3], sbits[2:0], command_code[4:0]};
         end else if (sshort) begin
            group.nbits = 5'd16;
            group.bits  = {8'b0, dbits, 1'b1, sbits[1:0], command_code[4:0]};
         end else begin
            group.nbits = 5'd24;
            group.bits  = {dbits, sbits, command_code};
         end
      end else begin
         group.nbits = {1'b0, vused};
         group.bits  = {16'b0, payload_byte >> (4'd8 - vused)};
      end
   end

endmodule

### sv/bhfc_queue.sv
// ----------------------------------------------------------------------------
// bhfc_queue
// Short register queue of bit groups between front and back.
// ----------------------------------------------------------------------------
module bhfc_queue
   import bhfc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      full,
   input  group_type push_group,
   output logic      head_valid,
   output group_type head_group,
   input  logic      pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   group_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;

   assign full       = (cnt_ff == CNT_FULL);
   assign do_push    = push_valid && !full;
   assign head_valid = (cnt_ff != '0);
   assign head_group = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");
`endif

endmodule

### sv/bhfc_back.sv
// ----------------------------------------------------------------------------
// bhfc_back
// Bit store, chunk cutter and output register.
// ----------------------------------------------------------------------------
module bhfc_back
   import bhfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [FS_W-1:0]    frame_size,
   input  logic               head_valid,
   input  group_type          head_group,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHUNK_W-1:0] rsp_chunk,
   output logic               rsp_last_chunk
);

   logic [STORE_W-1:0] store_ff, store_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic               valid_ff, valid_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               lastc_ff, lastc_in;

   logic [FS_W-1:0]    fs;
   logic [COUNT_W-1:0] fs6;
   logic               emit_full;
   logic               advance;
   logic [COUNT_W-1:0] rem_count;
   logic [STORE_W-1:0] shifted;
   logic [CHUNK_W-1:0] fs_mask;
   logic [FS_W-1:0]    pad;
   logic [CHUNK_W-1:0] rem16;
   logic [CHUNK_W-1:0] pad_chunk;

   assign fs        = (frame_size == '0) ? FS_W'(1) : frame_size;
   assign fs6       = COUNT_W'(fs);
   assign emit_full = (count_ff >= fs6);
   assign advance   = !valid_ff || !rsp_stall;
   assign rem_count = count_ff - fs6;
   assign shifted   = store_ff >> rem_count;
   assign fs_mask   = (CHUNK_W'(1) << fs) - CHUNK_W'(1);
   assign pad       = fs - count_ff[FS_W-1:0];
   assign rem16     = store_ff[CHUNK_W-1:0]
                      & ((CHUNK_W'(1) << count_ff[FS_W-1:0]) - CHUNK_W'(1));
   // 8 or more pad bits: drop a byte of padding and flag it with the marker
   assign pad_chunk = (pad >= 4'd8) ? ((rem16 << (pad - 4'd8)) | (CHUNK_W'(1) << fs))
                                    : (rem16 << pad);

   assign pop = head_valid && !emit_full && !last_ff;

   always_comb begin
      store_in = store_ff;
      count_in = count_ff;
      last_in  = last_ff;
      valid_in = valid_ff;
      chunk_in = chunk_ff;
      lastc_in = lastc_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (emit_full) begin
         if (advance) begin
            valid_in = 1'b1;
            chunk_in = shifted[CHUNK_W-1:0] & fs_mask;
            lastc_in = last_ff && (rem_count == '0);
            count_in = rem_count;
            if (rem_count == '0) begin
               last_in = 1'b0;
            end
         end
      end else if (last_ff) begin
         if (advance) begin
            valid_in = (count_ff != '0);
            chunk_in = pad_chunk;
            lastc_in = 1'b1;
            count_in = '0;
            store_in = '0;
            last_in  = 1'b0;
         end
      end else if (pop) begin
         last_in = head_group.last;
         if (head_group.clear) begin
            store_in = STORE_W'(head_group.bits);
            count_in = COUNT_W'(head_group.nbits);
         end else begin
            store_in = (store_ff << head_group.nbits) | STORE_W'(head_group.bits);
            count_in = count_ff + COUNT_W'(head_group.nbits);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         store_ff <= store_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
      lastc_ff <= lastc_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_chunk      = chunk_ff;
   assign rsp_last_chunk = lastc_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(38)) else $error("bit store overflow");
   a_pop_below_frame: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff < fs6) && !last_ff) else $error("pop with chunk pending");
`endif

endmodule

### sv/bus_header_and_frame_chunker.sv
// ----------------------------------------------------------------------------
// bus_header_and_frame_chunker
// Transmit serializer: packs bus headers and payload bits into frame chunks.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input beats, valid/stall. kind 0 is a header that starts a
//            message (1..3 bytes), kind 1 a payload byte with valid_bits
//            used high bits. last_item closes the message.
//   rsp_*  : output chunks, valid/stall, one chunk of frame_size bits per
//            beat, MSB first; the final chunk is left-aligned and flagged by
//            rsp_last_chunk, with a marker at bit frame_size when 8 or more
//            pad bits were needed.
//   csr_*  : frame_size write port, always ready; write only while idle.
// Path: a beat lands in the queue at acceptance; the back end pops it into
//   the bit store, and each chunk cut from it is held in the output register.
// Flow: the back end absorbs a queued item only while no chunk is pending,
//   then cuts its chunks one by one (the padded final chunk as a step of its
//   own); the queue lets the front accept a beat each cycle until it fills.
// Reset: frame_size returns to 11, the queue empties and pending bits drop.
// A stalled output holds its chunk; the back end then stops once its next
//   chunk is pending and the queue fills, after which req_stall rises.
// ----------------------------------------------------------------------------
module bus_header_and_frame_chunker
   import bhfc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [7:0]  req_dest_addr,
   input  logic signed [7:0]  req_source_addr,
   input  logic [7:0]         req_command_code,
   input  logic [7:0]         req_payload_byte,
   input  logic [3:0]         req_valid_bits,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHUNK_W-1:0] rsp_chunk,
   output logic               rsp_last_chunk,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [FS_W-1:0]    csr_frame_size
);

   logic [FS_W-1:0] frame_size_ff;
   group_type       front_group;
   group_type       head_group;
   logic            head_valid;
   logic            pop;
   logic            q_full;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_size_ff <= csr_frame_size;
      end
   end

   bhfc_front u_front (
      .kind         (req_kind),
      .dest_addr    (req_dest_addr),
      .source_addr  (req_source_addr),
      .command_code (req_command_code),
      .payload_byte (req_payload_byte),
      .valid_bits   (req_valid_bits),
      .last_item    (req_last_item),
      .group        (front_group)
   );

   bhfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .full       (q_full),
      .push_group (front_group),
      .head_valid (head_valid),
      .head_group (head_group),
      .pop        (pop)
   );

   bhfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame_size     (frame_size_ff),
      .head_valid     (head_valid),
      .head_group     (head_group),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_chunk      (rsp_chunk),
      .rsp_last_chunk (rsp_last_chunk)
   );

endmodule
